### rtl/plist_pkg.sv
// Shared constants, codes and structs for the positional list engine.
package plist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 5;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);

  typedef logic [FUNC_W-1:0]     func_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam func_t OP_INSERT  = 3'd0;
  localparam func_t OP_REMOVE  = 3'd1;
  localparam func_t OP_GET     = 3'd2;
  localparam func_t OP_REVERSE = 3'd3;
  localparam func_t OP_CLEAR   = 3'd4;

  typedef struct packed {
    func_t func;
    pos_t  position;
    word_t data;
  } req_t;

  typedef struct packed {
    logic  ok;
    word_t data_out;
    pos_t  length;
  } rsp_t;

endpackage

### rtl/plist_in_if.sv
// Input word channel: operation, position and element word.
interface plist_in_if import plist_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  pos_t  position;
  word_t data_in;

  modport source(output valid, func, position, data_in, input ready);
  modport sink(input valid, func, position, data_in, output ready);
endinterface

### rtl/plist_out_if.sv
// Result word channel: status, read element and list length.
interface plist_out_if import plist_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  ok;
  word_t data_out;
  pos_t  length;

  modport source(output valid, ok, data_out, length, input ready);
  modport sink(input valid, ok, data_out, length, output ready);
endinterface

### rtl/positional_list_engine_core.sv
// Positional list engine top level: input register, list store and result register.
//
// Bounded ordered list of up to 16 32-bit words. Each input word carries one
// operation (insert, remove, get, reverse, clear) and yields exactly one result
// word with status, read element and new length. One operation is accepted
// every cycle while the result side keeps up; each input word passes through the
// input register, then the store update and result register in one pass. A
// stalled result holds the input register, and input ready drops only while both
// registers are full.
// Reverse flips an orientation flag rather than moving entries. Entries are not
// cleared at reset; only positions below the current length are ever read.
module positional_list_engine_core import plist_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  plist_in_if.sink     in_ch,
  plist_out_if.source  out_ch
);

  logic s0_valid_r;
  req_t s0_req_r;
  logic out_valid_r;
  rsp_t out_rsp_r;
  logic adv;
  logic exec;
  rsp_t rsp;

  assign adv          = !out_valid_r || out_ch.ready;
  assign exec         = s0_valid_r && adv;
  assign in_ch.ready  = !s0_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s0_valid_r <= in_ch.valid;
      if (adv) out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_req_r.func     <= in_ch.func;
      s0_req_r.position <= in_ch.position;
      s0_req_r.data     <= in_ch.data_in;
    end
    if (exec) out_rsp_r <= rsp;
  end

  plist_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (exec),
    .req   (s0_req_r),
    .rsp   (rsp)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.ok       = out_rsp_r.ok;
  assign out_ch.data_out = out_rsp_r.data_out;
  assign out_ch.length   = out_rsp_r.length;

endmodule

### rtl/plist_store.sv
// Entry register file, length and orientation flag; applies one operation per cycle while exec is high.
module plist_store import plist_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic exec,
  input  req_t req,
  output rsp_t rsp
);

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  word_t mem_r [CAPACITY];
  word_t mem_nxt [CAPACITY];
  cnt_t  count_r, count_nxt;
  logic  rev_r, rev_nxt;

  cnt_t  pos_c;
  cnt_t  q_ins;
  cnt_t  q_sel;
  idx_t  qi_ins;
  idx_t  qi_sel;
  logic  ins_ok, sel_ok;
  logic  do_ins, do_rem;
  word_t get_word;

  // Reverse only flips the logical-to-physical mapping of the held entries.
  always_comb begin
    pos_c   = cnt_t'(req.position);
    ins_ok  = (pos_c <= count_r) && (count_r < CAP_CNT);
    sel_ok  = pos_c < count_r;
    q_ins   = rev_r ? cnt_t'(count_r - pos_c) : pos_c;
    q_sel   = rev_r ? cnt_t'(count_r - pos_c - cnt_t'(1)) : pos_c;
    qi_ins  = q_ins[IDX_W-1:0];
    qi_sel  = q_sel[IDX_W-1:0];
    get_word = mem_r[qi_sel];
    do_ins  = exec && (req.func == OP_INSERT) && ins_ok;
    do_rem  = exec && (req.func == OP_REMOVE) && sel_ok;

    count_nxt = count_r;
    rev_nxt   = rev_r;
    rsp.ok       = 1'b0;
    rsp.data_out = '0;

    unique case (req.func)
      OP_INSERT: begin
        rsp.ok = ins_ok;
        if (ins_ok) count_nxt = count_r + cnt_t'(1);
      end
      OP_REMOVE: begin
        rsp.ok = sel_ok;
        if (sel_ok) count_nxt = count_r - cnt_t'(1);
      end
      OP_GET: begin
        rsp.ok = sel_ok;
        if (sel_ok) rsp.data_out = get_word;
      end
      OP_REVERSE: begin
        rsp.ok  = 1'b1;
        rev_nxt = ~rev_r;
      end
      OP_CLEAR: begin
        rsp.ok    = 1'b1;
        count_nxt = '0;
        rev_nxt   = 1'b0;
      end
      default: begin
        rsp.ok = 1'b0;
      end
    endcase
    rsp.length = pos_t'(count_nxt);

    for (int k = 0; k < CAPACITY; k++) begin
      mem_nxt[k] = mem_r[k];
      if (do_ins) begin
        if (idx_t'(k) == qi_ins) begin
          mem_nxt[k] = req.data;
        end else if ((idx_t'(k) > qi_ins) && (k > 0)) begin
          mem_nxt[k] = mem_r[(k > 0) ? k - 1 : 0];
        end
      end else if (do_rem) begin
        if ((idx_t'(k) >= qi_sel) && (k < CAPACITY - 1)) begin
          mem_nxt[k] = mem_r[(k < CAPACITY - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (exec) begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      mem_r[k] <= mem_nxt[k];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("list length above capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (req.func == OP_CLEAR) |=> (count_r == '0) && !rev_r)
    else $error("clear left entries or orientation");

  a_insert_len: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> count_r == $past(count_r) + cnt_t'(1))
    else $error("insert did not grow list by one");

  a_remove_len: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem |=> count_r == $past(count_r) - cnt_t'(1))
    else $error("remove did not shrink list by one");

  a_get_static: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (req.func == OP_GET) |=> (count_r == $past(count_r)) && (rev_r == $past(rev_r)))
    else $error("get changed list state");

endmodule
